// ===== src/blc_pkg.sv =====
package blc_pkg;

  // number of digits fitted on the display
  localparam int DIGIT_COUNT = 4;

  // input item kinds
  localparam logic [2:0] KIND_PACKET = 3'd0;
  localparam logic [2:0] KIND_INIT   = 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd2;
  localparam logic [2:0] KIND_SET    = 3'd3;
  localparam logic [2:0] KIND_NOP    = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_ACK  = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_BUTTONS_ON   = 3'd0;
  localparam logic [2:0] REG_LED_USER     = 3'd1;
  localparam logic [2:0] REG_LED_SET      = 3'd2;
  localparam logic [2:0] REG_ACK          = 3'd3;
  localparam logic [2:0] REG_BUTTON_EVENT = 3'd4;
  localparam logic [2:0] REG_DEVICE_RESET = 3'd5;

  // fixed byte of a led frame and the decimal point bit
  localparam logic [7:0] FRAME_MASK_BYTE = 8'h0F;
  localparam logic [7:0] POINT_BIT       = 8'h10;

  // transmit sequence positions: init bytes, then the led frame
  localparam logic [3:0] SEQ_BUTTONS_ON = 4'd0;
  localparam logic [3:0] SEQ_INIT_USER  = 4'd1;
  localparam logic [3:0] SEQ_LED_USER   = 4'd2;
  localparam logic [3:0] SEQ_LED_SET    = 4'd3;
  localparam logic [3:0] SEQ_MASK       = 4'd4;
  localparam logic [3:0] SEQ_DIGIT0     = 4'd5;
  localparam logic [3:0] SEQ_LAST       = 4'd8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  pkt_first;
    logic [7:0]  pkt_second;
    logic [7:0]  pkt_third;
    logic [27:0] led_word;
  } in_beat_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [1:0] status;
    logic [7:0] button_bits;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] buttons_on;
    logic [7:0] led_user;
    logic [7:0] led_set;
    logic [7:0] ack;
    logic [7:0] button_event;
    logic [7:0] device_reset;
  } opcodes_t;

  typedef enum logic [1:0] {
    JOB_EMPTY,
    JOB_INIT,
    JOB_LEDS,
    JOB_REPLAY
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [1:0]  status;
    logic [27:0] word;
    logic [7:0]  button_bits;
  } job_t;

  // seven-segment pattern for one hex digit
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'h0: pat = 8'hE7;
      4'h1: pat = 8'h06;
      4'h2: pat = 8'hCB;
      4'h3: pat = 8'h8F;
      4'h4: pat = 8'h2E;
      4'h5: pat = 8'hAD;
      4'h6: pat = 8'hED;
      4'h7: pat = 8'h86;
      4'h8: pat = 8'hEF;
      4'h9: pat = 8'hAE;
      4'hA: pat = 8'hEE;
      4'hB: pat = 8'h6D;
      4'hC: pat = 8'hE1;
      4'hD: pat = 8'h4F;
      4'hE: pat = 8'hE9;
      default: pat = 8'hE8;
    endcase
    return pat;
  endfunction

endpackage

// ===== src/blc_front.sv =====
module blc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  blc_pkg::in_beat_t in_beat,
  input  blc_pkg::opcodes_t opcodes,
  output logic              job_valid,
  input  logic              job_ready,
  output blc_pkg::job_t     job
);

  logic        ack_pending;
  logic        ack_pending_next;
  logic [7:0]  button_store;
  logic [7:0]  button_store_next;
  logic [27:0] saved_word;
  logic [27:0] saved_word_next;
  logic [3:0]  arrows;
  logic [7:0]  event_bits;
  logic        accept;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;

  // invert active-low keys and swap the two middle arrow bits
  always_comb begin
    arrows     = ~in_beat.pkt_third[3:0];
    event_bits = {arrows[3], arrows[1], arrows[2], arrows[0], ~in_beat.pkt_second[3:0]};
  end

  // classify the beat and work out the link state it leaves
  always_comb begin
    ack_pending_next  = ack_pending;
    button_store_next = button_store;
    saved_word_next   = saved_word;
    job.kind          = blc_pkg::JOB_EMPTY;
    job.status        = blc_pkg::STATUS_OK;
    job.word          = in_beat.led_word;
    case (in_beat.kind)
      blc_pkg::KIND_PACKET: begin
        if (in_beat.pkt_first == opcodes.ack) begin
          ack_pending_next = 1'b1;
        end else if (in_beat.pkt_first == opcodes.button_event) begin
          button_store_next = event_bits;
        end else if (in_beat.pkt_first == opcodes.device_reset) begin
          job.kind          = blc_pkg::JOB_REPLAY;
          job.word          = saved_word;
          ack_pending_next  = 1'b0;
          button_store_next = '0;
        end
      end
      blc_pkg::KIND_INIT: begin
        job.kind          = blc_pkg::JOB_INIT;
        ack_pending_next  = 1'b0;
        button_store_next = '0;
        saved_word_next   = '0;
      end
      blc_pkg::KIND_SET: begin
        if (!ack_pending) begin
          job.status = blc_pkg::STATUS_NO_ACK;
        end else begin
          job.kind         = blc_pkg::JOB_LEDS;
          ack_pending_next = 1'b0;
          saved_word_next  = in_beat.led_word;
        end
      end
      blc_pkg::KIND_READ, blc_pkg::KIND_NOP: begin
        job.status = blc_pkg::STATUS_OK;
      end
      default: begin
        job.status = blc_pkg::STATUS_INVALID;
      end
    endcase
    job.button_bits = button_store_next;
  end

  // link state
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_pending  <= 1'b0;
      button_store <= '0;
      saved_word   <= '0;
    end else if (accept) begin
      ack_pending  <= ack_pending_next;
      button_store <= button_store_next;
      saved_word   <= saved_word_next;
    end
  end

endmodule

// ===== src/blc_queue.sv =====
module blc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  blc_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output blc_pkg::job_t pop_job
);

  blc_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/blc_back.sv =====
module blc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  blc_pkg::job_t      job,
  input  blc_pkg::opcodes_t  opcodes,
  output logic               out_valid,
  input  logic               out_ready,
  output blc_pkg::out_beat_t out_beat
);

  logic               started;
  logic [3:0]         idx;
  logic [3:0]         idx_cur;
  logic [3:0]         idx_end;
  logic [1:0]         dsel;
  logic [7:0]         digit_byte;
  logic [7:0]         seq_byte;
  logic               beat_last;
  logic               load;
  blc_pkg::out_beat_t beat;

  // where the sequence of the head job starts and ends
  always_comb begin
    idx_cur = started ? idx : blc_pkg::SEQ_BUTTONS_ON;
    idx_end = blc_pkg::SEQ_LAST;
    case (job.kind)
      blc_pkg::JOB_INIT: begin
        idx_end = blc_pkg::SEQ_INIT_USER;
      end
      blc_pkg::JOB_LEDS: begin
        if (!started) begin
          idx_cur = blc_pkg::SEQ_LED_USER;
        end
      end
      default: begin
        idx_end = blc_pkg::SEQ_LAST;
      end
    endcase
    beat_last = (job.kind == blc_pkg::JOB_EMPTY) || (idx_cur == idx_end);
  end

  // digit byte: segment pattern plus decimal point when enabled, zero when the digit is off
  always_comb begin
    dsel       = 2'(idx_cur - blc_pkg::SEQ_DIGIT0);
    digit_byte = '0;
    if ((3'(dsel) < 3'(blc_pkg::DIGIT_COUNT)) && job.word[16 + dsel]) begin
      digit_byte = blc_pkg::seg_pattern(job.word[4 * dsel +: 4]);
      if (job.word[24 + dsel]) begin
        digit_byte = digit_byte | blc_pkg::POINT_BIT;
      end
    end
  end

  // byte at the current sequence position
  always_comb begin
    case (idx_cur)
      blc_pkg::SEQ_BUTTONS_ON: seq_byte = opcodes.buttons_on;
      blc_pkg::SEQ_INIT_USER:  seq_byte = opcodes.led_user;
      blc_pkg::SEQ_LED_USER:   seq_byte = opcodes.led_user;
      blc_pkg::SEQ_LED_SET:    seq_byte = opcodes.led_set;
      blc_pkg::SEQ_MASK:       seq_byte = blc_pkg::FRAME_MASK_BYTE;
      default:                 seq_byte = digit_byte;
    endcase
  end

  // assemble the result beat
  always_comb begin
    beat.last        = beat_last;
    beat.button_bits = job.button_bits;
    if (job.kind == blc_pkg::JOB_EMPTY) begin
      beat.tx_valid = 1'b0;
      beat.tx_byte  = '0;
      beat.status   = job.status;
    end else begin
      beat.tx_valid = 1'b1;
      beat.tx_byte  = seq_byte;
      beat.status   = blc_pkg::STATUS_OK;
    end
  end

  assign load      = job_valid && (!out_valid || out_ready);
  assign job_ready = load && beat_last;

  // sequence position
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      idx     <= '0;
    end else if (load) begin
      started <= !beat_last;
      idx     <= idx_cur + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_beat <= beat;
    end
  end

endmodule

// ===== src/button_led_controller_link.sv =====
// path: with nothing queued ahead, the first result beat of an item is written into
// the job queue and then into the output register before it shows on the output
// throughput: input beats are taken one per cycle while the two-entry job queue has
// room; unless the output stalls, the sequencer moves one result beat per cycle, so an
// item holds it for its results (1, 2 for init, 7 for a led frame, 9 for a device reset)
// reset: synchronous, clears link state, job queue and output valid; opcode
// registers return to their default values
module button_led_controller_link (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  blc_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output blc_pkg::out_beat_t out_beat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  blc_pkg::opcodes_t opcodes;
  blc_pkg::job_t     front_job;
  blc_pkg::job_t     head_job;
  logic              front_valid;
  logic              front_ready;
  logic              head_valid;
  logic              head_ready;

  // opcode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      opcodes.buttons_on   <= 8'd3;
      opcodes.led_user     <= 8'd5;
      opcodes.led_set      <= 8'd6;
      opcodes.ack          <= 8'd64;
      opcodes.button_event <= 8'd68;
      opcodes.device_reset <= 8'd69;
    end else if (cfg_we) begin
      case (cfg_index)
        blc_pkg::REG_BUTTONS_ON:   opcodes.buttons_on   <= cfg_data;
        blc_pkg::REG_LED_USER:     opcodes.led_user     <= cfg_data;
        blc_pkg::REG_LED_SET:      opcodes.led_set      <= cfg_data;
        blc_pkg::REG_ACK:          opcodes.ack          <= cfg_data;
        blc_pkg::REG_BUTTON_EVENT: opcodes.button_event <= cfg_data;
        blc_pkg::REG_DEVICE_RESET: opcodes.device_reset <= cfg_data;
        default:                   opcodes              <= opcodes;
      endcase
    end
  end

  // classify input beats
  blc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .opcodes   (opcodes),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  // jobs waiting for the sequencer
  blc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_job    (head_job)
  );

  // emit result beats
  blc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job_ready (head_ready),
    .job       (head_job),
    .opcodes   (opcodes),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule
